FILE: sv/liu_pkg.sv
`timescale 1ns / 1ps

package liu_pkg;

  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam logic [REG_IDX_W-1:0] EP_INDEX = 5'd30;

  // Request codes.
  localparam logic [1:0] REQ_ISSUE = 2'd0;
  localparam logic [1:0] REQ_RESP  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_SETPC = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_READ_REQ   = 3'd0;
  localparam logic [2:0] ST_LOAD_DONE  = 3'd1;
  localparam logic [2:0] ST_BUS_ABORT  = 3'd2;
  localparam logic [2:0] ST_WRITE_DONE = 3'd3;
  localparam logic [2:0] ST_IGNORED    = 3'd4;

  // Access size codes.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Load kinds: short, 16-bit displacement, 23-bit displacement.
  localparam logic [3:0] K_SLD_B   = 4'd0;
  localparam logic [3:0] K_SLD_BU  = 4'd1;
  localparam logic [3:0] K_SLD_HU  = 4'd2;
  localparam logic [3:0] K_SLD_H   = 4'd3;
  localparam logic [3:0] K_SLD_W   = 4'd4;
  localparam logic [3:0] K_LD16_B  = 4'd5;
  localparam logic [3:0] K_LD16_BU = 4'd6;
  localparam logic [3:0] K_LD16_H  = 4'd7;
  localparam logic [3:0] K_LD16_W  = 4'd8;
  localparam logic [3:0] K_LD16_HU = 4'd9;
  localparam logic [3:0] K_LD23_B  = 4'd10;
  localparam logic [3:0] K_LD23_BU = 4'd11;
  localparam logic [3:0] K_LD23_H  = 4'd12;
  localparam logic [3:0] K_LD23_HU = 4'd13;
  localparam logic [3:0] K_LD23_W  = 4'd14;
  localparam logic [3:0] K_NONE    = 4'd15;

  function automatic logic [1:0] kind_size(input logic [3:0] kind);
    logic [1:0] sz;
    case (kind) inside
      K_SLD_B, K_SLD_BU, K_LD16_B, K_LD16_BU, K_LD23_B, K_LD23_BU: sz = SZ_BYTE;
      K_SLD_HU, K_SLD_H, K_LD16_H, K_LD16_HU, K_LD23_H, K_LD23_HU: sz = SZ_HALF;
      default:                                                     sz = SZ_WORD;
    endcase
    return sz;
  endfunction

  function automatic logic kind_signed(input logic [3:0] kind);
    logic s;
    case (kind) inside
      K_SLD_B, K_SLD_H, K_LD16_B, K_LD16_H, K_LD23_B, K_LD23_H: s = 1'b1;
      default:                                                 s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] kind_pcinc(input logic [3:0] kind);
    logic [2:0] inc;
    if (kind <= K_SLD_W) begin
      inc = 3'd2;
    end else if (kind <= K_LD16_HU) begin
      inc = 3'd4;
    end else begin
      inc = 3'd6;
    end
    return inc;
  endfunction

  function automatic logic [31:0] build_disp(input logic [3:0] kind, input logic [15:0] m,
                                             input logic [6:0] x);
    logic [31:0] d;
    case (kind) inside
      K_SLD_B:             d = {25'd0, m[5:0], x[0]};
      K_SLD_BU:            d = {28'd0, m[3:0]};
      K_SLD_HU:            d = {27'd0, m[3:0], 1'b0};
      K_SLD_H:             d = {24'd0, m[5:0], x[0], 1'b0};
      K_SLD_W:             d = {24'd0, m[5:0], 2'b00};
      K_LD16_B, K_LD16_BU: d = {{16{m[14]}}, m[14:0], x[0]};
      K_LD16_H, K_LD16_W, K_LD16_HU:
                           d = {{16{m[14]}}, m[14:0], 1'b0};
      default:             d = {{9{m[15]}}, m[15:0], x[6:0]};
    endcase
    return d;
  endfunction

  function automatic logic [31:0] extend_data(input logic [3:0] kind, input logic [31:0] v);
    logic [31:0] r;
    logic        s;
    s = kind_signed(kind);
    case (kind_size(kind))
      SZ_BYTE: r = {{24{s & v[7]}}, v[7:0]};
      SZ_HALF: r = {{16{s & v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/load_instruction_unit_core.sv
`timescale 1ns / 1ps

// A result beat appears on the output register in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the output register lets a new beat in while
// the previous result is being taken, so only a stalled, full output holds the input.
// The per-beat path is one register file read, a displacement build and one 32-bit add.
// Reset (synchronous, rst_n low): all 32 registers, the PC and the pending load clear.
module load_instruction_unit_core
  import liu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_load_kind,
  input  logic [4:0]  in_base_reg,
  input  logic [4:0]  in_dest_reg,
  input  logic [15:0] in_disp_main,
  input  logic [6:0]  in_disp_extra,
  input  logic [31:0] in_data_word,
  input  logic        in_bus_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_addr,
  output logic [1:0]  out_access_size,
  output logic [4:0]  out_written_reg,
  output logic [31:0] out_written_value,
  output logic [31:0] out_pc_value
);

  // Architectural state. The register file is small enough to live in flops,
  // so the synchronous reset clears every entry together with the rest of the state.
  logic [31:0]          regs_r [NUM_REGS];
  logic [31:0]          pc_r;
  logic                 pend_valid_r;
  logic [3:0]           pend_kind_r;
  logic [REG_IDX_W-1:0] pend_dest_r;

  // Output register.
  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [31:0]          out_read_addr_r;
  logic [1:0]           out_access_size_r;
  logic [4:0]           out_written_reg_r;
  logic [31:0]          out_written_value_r;
  logic [31:0]          out_pc_value_r;

  // Next values computed from the incoming beat and the current state.
  logic [2:0]           status_nxt;
  logic [31:0]          addr_nxt;
  logic [1:0]           size_nxt;
  logic [4:0]           wreg_nxt;
  logic [31:0]          wval_nxt;
  logic [31:0]          pc_nxt;
  logic                 pend_valid_nxt;
  logic [3:0]           pend_kind_nxt;
  logic [REG_IDX_W-1:0] pend_dest_nxt;
  logic                 rf_we;
  logic [REG_IDX_W-1:0] base_idx;
  logic                 in_fire;

  // The input is taken whenever the output register is empty or drains this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Short loads always address off the element pointer.
  assign base_idx = (in_load_kind <= K_SLD_W) ? EP_INDEX : in_base_reg;

  always_comb begin
    status_nxt     = ST_IGNORED;
    addr_nxt       = '0;
    size_nxt       = SZ_BYTE;
    wreg_nxt       = '0;
    wval_nxt       = '0;
    pc_nxt         = pc_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_dest_nxt  = pend_dest_r;
    rf_we          = 1'b0;
    unique case (in_req_type)
      REQ_ISSUE: begin
        // A second issue while a load is outstanding is dropped, as is the unused kind.
        if (!pend_valid_r && in_load_kind != K_NONE) begin
          addr_nxt       = regs_r[base_idx] +
                           build_disp(in_load_kind, in_disp_main, in_disp_extra);
          size_nxt       = kind_size(in_load_kind);
          pend_valid_nxt = 1'b1;
          pend_kind_nxt  = in_load_kind;
          pend_dest_nxt  = in_dest_reg;
          status_nxt     = ST_READ_REQ;
        end
      end
      REQ_RESP: begin
        if (pend_valid_r) begin
          size_nxt       = kind_size(pend_kind_r);
          pend_valid_nxt = 1'b0;
          if (in_bus_error) begin
            // Aborted load: neither the register file nor the PC moves.
            status_nxt = ST_BUS_ABORT;
          end else begin
            wreg_nxt   = pend_dest_r;
            wval_nxt   = extend_data(pend_kind_r, in_data_word);
            rf_we      = 1'b1;
            pc_nxt     = pc_r + {29'd0, kind_pcinc(pend_kind_r)};
            status_nxt = ST_LOAD_DONE;
          end
        end
      end
      REQ_WRITE: begin
        // Register writes bypass any pending load; register 0 is writable.
        wreg_nxt   = in_dest_reg;
        wval_nxt   = in_data_word;
        rf_we      = 1'b1;
        status_nxt = ST_WRITE_DONE;
      end
      REQ_SETPC: begin
        pc_nxt     = in_data_word;
        status_nxt = ST_WRITE_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      pc_r         <= '0;
      pend_valid_r <= 1'b0;
      pend_kind_r  <= '0;
      pend_dest_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        if (rf_we) begin
          regs_r[wreg_nxt] <= wval_nxt;
        end
        pc_r         <= pc_nxt;
        pend_valid_r <= pend_valid_nxt;
        pend_kind_r  <= pend_kind_nxt;
        pend_dest_r  <= pend_dest_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; loaded only with a new beat, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r        <= status_nxt;
      out_read_addr_r     <= addr_nxt;
      out_access_size_r   <= size_nxt;
      out_written_reg_r   <= wreg_nxt;
      out_written_value_r <= wval_nxt;
      out_pc_value_r      <= pc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_addr     = out_read_addr_r;
  assign out_access_size   = out_access_size_r;
  assign out_written_reg   = out_written_reg_r;
  assign out_written_value = out_written_value_r;
  assign out_pc_value      = out_pc_value_r;

endmodule

FILE: sv/liu_checker.sv
`timescale 1ns / 1ps

module liu_checker
  import liu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic [4:0]  in_dest_reg,
  input logic [31:0] in_data_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_read_addr,
  input logic [1:0]  out_access_size,
  input logic [4:0]  out_written_reg,
  input logic [31:0] out_written_value,
  input logic [31:0] out_pc_value
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_read_addr) && $stable(out_access_size) && $stable(out_written_reg) &&
      $stable(out_pc_value) && $stable(out_written_value))
    else $error("result beat changed while stalled");

  // A set-pc beat produces a write-done result carrying the new PC.
  a_setpc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_SETPC |=>
      out_valid && out_status == ST_WRITE_DONE && out_pc_value == $past(in_data_word))
    else $error("set pc result mismatch");

  // A register write beat reports the register and value it wrote.
  a_regwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_WRITE |=>
      out_valid && out_status == ST_WRITE_DONE &&
      out_written_reg == $past(in_dest_reg) && out_written_value == $past(in_data_word))
    else $error("register write result mismatch");

  // Read requests, aborted loads and ignored beats never report a register write.
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_READ_REQ || out_status == ST_IGNORED ||
                  out_status == ST_BUS_ABORT) |->
      out_written_reg == 5'd0 && out_written_value == 32'd0)
    else $error("spurious register write reported");

endmodule

bind load_instruction_unit_core liu_checker u_liu_checker (.*);

FILE: verif/load_unit_checker.sv
`timescale 1ns / 1ps

module load_unit_checker
  import liu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_load_kind,
  input  logic [4:0]  in_base_reg,
  input  logic [4:0]  in_dest_reg,
  input  logic [15:0] in_disp_main,
  input  logic [6:0]  in_disp_extra,
  input  logic [31:0] in_data_word,
  input  logic        in_bus_error,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_read_addr,
  input  logic [1:0]  out_access_size,
  input  logic [4:0]  out_written_reg,
  input  logic [31:0] out_written_value,
  input  logic [31:0] out_pc_value,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_checked
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_addr;
    logic [1:0]  access_size;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic [31:0] pc_value;
  } load_result_t;

  // Architectural state as the load path sees it.
  logic [31:0]  gpr [NUM_REGS];
  logic [31:0]  pc;
  logic         load_waiting;
  logic [3:0]   waiting_kind;
  logic [4:0]   waiting_dest;
  load_result_t results_due [$];

  function automatic logic [1:0] access_width(input logic [3:0] kind);
    case (kind) inside
      K_SLD_B, K_SLD_BU, K_LD16_B, K_LD16_BU, K_LD23_B, K_LD23_BU: return SZ_BYTE;
      K_SLD_W, K_LD16_W, K_LD23_W:                                 return SZ_WORD;
      default:                                                     return SZ_HALF;
    endcase
  endfunction

  function automatic logic [2:0] pc_advance(input logic [3:0] kind);
    if (kind < K_LD16_B) begin
      return 3'd2;
    end else if (kind < K_LD23_B) begin
      return 3'd4;
    end
    return 3'd6;
  endfunction

  function automatic logic [31:0] displacement(input logic [3:0] kind, input logic [15:0] m,
                                               input logic [6:0] x);
    logic [15:0] d16;
    logic [22:0] d23;
    logic [31:0] d;
    d16 = {m[14:0], x[0]};
    d23 = {m, x};
    case (kind) inside
      K_SLD_B:   d = (32'(m[5:0]) << 1) | 32'(x[0]);
      K_SLD_BU:  d = 32'(m[3:0]);
      K_SLD_HU:  d = 32'(m[3:0]) << 1;
      K_SLD_H:   d = ((32'(m[5:0]) << 1) | 32'(x[0])) << 1;
      K_SLD_W:   d = 32'(m[5:0]) << 2;
      K_LD16_B, K_LD16_BU: d = {{16{d16[15]}}, d16};
      K_LD16_H, K_LD16_W, K_LD16_HU: begin
        // Bit 0 of the halfword/word forms is an opcode bit, not an offset bit.
        d16[0] = 1'b0;
        d = {{16{d16[15]}}, d16};
      end
      default:   d = {{9{d23[22]}}, d23};
    endcase
    return d;
  endfunction

  function automatic logic [31:0] widen_data(input logic [3:0] kind, input logic [31:0] v);
    logic fill;
    fill = 1'b0;
    case (access_width(kind))
      SZ_BYTE: begin
        if (kind inside {K_SLD_B, K_LD16_B, K_LD23_B}) fill = v[7];
        return {{24{fill}}, v[7:0]};
      end
      SZ_HALF: begin
        if (kind inside {K_SLD_H, K_LD16_H, K_LD23_H}) fill = v[15];
        return {{16{fill}}, v[15:0]};
      end
      default: return v;
    endcase
  endfunction

  // Advances the state by one accepted input beat and returns the result it owes.
  task automatic apply_request(output load_result_t r);
    logic [4:0] base;
    r = '0;
    r.status = ST_IGNORED;
    case (in_req_type)
      REQ_ISSUE: begin
        if (!load_waiting && in_load_kind != K_NONE) begin
          base = (in_load_kind <= K_SLD_W) ? EP_INDEX : in_base_reg;
          r.status = ST_READ_REQ;
          r.read_addr = gpr[base] + displacement(in_load_kind, in_disp_main, in_disp_extra);
          r.access_size = access_width(in_load_kind);
          load_waiting = 1'b1;
          waiting_kind = in_load_kind;
          waiting_dest = in_dest_reg;
        end
      end
      REQ_RESP: begin
        if (load_waiting) begin
          r.access_size = access_width(waiting_kind);
          load_waiting = 1'b0;
          if (in_bus_error) begin
            r.status = ST_BUS_ABORT;
          end else begin
            r.status = ST_LOAD_DONE;
            r.written_reg = waiting_dest;
            r.written_value = widen_data(waiting_kind, in_data_word);
            gpr[waiting_dest] = r.written_value;
            pc = pc + 32'(pc_advance(waiting_kind));
          end
        end
      end
      REQ_WRITE: begin
        r.status = ST_WRITE_DONE;
        r.written_reg = in_dest_reg;
        r.written_value = in_data_word;
        gpr[in_dest_reg] = in_data_word;
      end
      default: begin
        r.status = ST_WRITE_DONE;
        pc = in_data_word;
      end
    endcase
    r.pc_value = pc;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    load_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
      pc = '0;
      load_waiting = 1'b0;
      waiting_kind = '0;
      waiting_dest = '0;
      results_due.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      // An output beat always belongs to an earlier input beat, so compare first.
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with status %0d arrived with no result expected", out_status);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("read_addr", want.read_addr, out_read_addr);
          check_field("access_size", 32'(want.access_size), 32'(out_access_size));
          check_field("written_reg", 32'(want.written_reg), 32'(out_written_reg));
          check_field("written_value", want.written_value, out_written_value);
          check_field("pc_value", want.pc_value, out_pc_value);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        apply_request(want);
        results_due.push_back(want);
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the load unit. All prediction and comparison lives in
// load_unit_checker, which sits beside the block and watches both channels.
module tb
  import liu_pkg::*;
();

  // Far beyond the slowest legal run of about 1400 beats.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Length of the one long output hold-off that fills the block and stalls its input.
  localparam int unsigned STALL_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_WRITE;
  logic [3:0]  in_load_kind = K_SLD_B;
  logic [4:0]  in_base_reg = '0;
  logic [4:0]  in_dest_reg = '0;
  logic [15:0] in_disp_main = '0;
  logic [6:0]  in_disp_extra = '0;
  logic [31:0] in_data_word = '0;
  logic        in_bus_error = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_read_addr;
  logic [1:0]  out_access_size;
  logic [4:0]  out_written_reg;
  logic [31:0] out_written_value;
  logic [31:0] out_pc_value;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;

  // Idle percentages for the two sides; the stimulus process sets them per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        stall_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned useful_beats = 0;

  always #1 clk = ~clk;

  load_instruction_unit_core u_top (.*);

  load_unit_checker u_check (.*);

  // Give up if the run hangs; a stuck handshake never reaches the verdict below.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side. It takes beats at random, and once asked it holds ready low for a
  // long stretch so that the output register fills and the block refuses input.
  initial begin : result_sink
    int unsigned hold_left;
    logic        stall_done;
    hold_left = 0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        hold_left = STALL_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one input beat and returns once it has been accepted. Between beats the
  // sender may sit idle, as send_idle_pct sets. Beats the block is meant to ignore are
  // sent with counted cleared so that they do not advance the phase.
  task automatic send_beat(input logic [1:0] req, input logic [3:0] kind,
                           input logic [4:0] base, input logic [4:0] dest,
                           input logic [15:0] dmain, input logic [6:0] dextra,
                           input logic [31:0] data, input logic berr, input bit counted);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = req;
    in_load_kind = kind;
    in_base_reg = base;
    in_dest_reg = dest;
    in_disp_main = dmain;
    in_disp_extra = dextra;
    in_data_word = data;
    in_bus_error = berr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (counted) useful_beats++;
  endtask

  // One random phase. Most traffic is a complete load: an optional write that
  // primes the base register, the issue, sometimes an interloper while the load
  // is outstanding, and the bus response (now and then an error). The rest is
  // plain register writes, PC sets, and beats the block should ignore.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned beats);
    int unsigned goal;
    int unsigned pick;
    logic [3:0]  kind;
    logic [4:0]  base;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = useful_beats + beats;
    while (useful_beats < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        kind = 4'($urandom_range(0, 14));
        base = 5'($urandom);
        if ($urandom_range(0, 2) == 0) begin
          send_beat(REQ_WRITE, 4'($urandom), 5'($urandom),
                    (kind <= K_SLD_W) ? EP_INDEX : base,
                    16'($urandom), 7'($urandom), $urandom, 1'($urandom), 1'b1);
        end
        send_beat(REQ_ISSUE, kind, base, 5'($urandom), 16'($urandom), 7'($urandom),
                  $urandom, 1'($urandom), 1'b1);
        case ($urandom_range(0, 9))
          0: send_beat(REQ_ISSUE, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                       7'($urandom), $urandom, 1'($urandom), 1'b0);
          1: send_beat(REQ_WRITE, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                       7'($urandom), $urandom, 1'($urandom), 1'b1);
          2: send_beat(REQ_SETPC, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                       7'($urandom), $urandom, 1'($urandom), 1'b1);
          default: ;
        endcase
        send_beat(REQ_RESP, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                  7'($urandom), $urandom, ($urandom_range(0, 9) == 0), 1'b1);
      end else if (pick < 85) begin
        send_beat(REQ_WRITE, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                  7'($urandom), $urandom, 1'($urandom), 1'b1);
      end else if (pick < 90) begin
        send_beat(REQ_SETPC, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                  7'($urandom), $urandom, 1'($urandom), 1'b1);
      end else if (pick < 95) begin
        // No load is outstanding here, so this response is dropped.
        send_beat(REQ_RESP, 4'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                  7'($urandom), $urandom, 1'($urandom), 1'b0);
      end else begin
        send_beat(REQ_ISSUE, K_NONE, 5'($urandom), 5'($urandom), 16'($urandom),
                  7'($urandom), $urandom, 1'($urandom), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] dmain;
    logic [6:0]  dextra;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 75;

    // Directed opening. The element pointer sits just below the top of the address
    // space so that short-load offsets wrap past bit 31, and r31 holds the most
    // negative value as a base for the long forms.
    send_beat(REQ_WRITE, K_SLD_B, 5'd0, EP_INDEX, 16'h0000, 7'h00, 32'hFFFF_FF80, 1'b0, 1'b1);
    send_beat(REQ_WRITE, K_SLD_B, 5'd0, 5'd31, 16'h0000, 7'h00, 32'h8000_0000, 1'b0, 1'b1);
    // A response with nothing outstanding, and the unused load kind, are both dropped.
    send_beat(REQ_RESP, K_SLD_B, 5'd0, 5'd0, 16'h0000, 7'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_beat(REQ_ISSUE, K_NONE, 5'd31, 5'd1, 16'hFFFF, 7'h7F, 32'h0, 1'b0, 1'b0);

    // Every load kind once, with the displacement fields at their extremes: all ones,
    // and with only the sign bit of the 16-bit or 23-bit forms set. Kind 0 writes r0,
    // which the block does not protect.
    for (int k = 0; k < 15; k++) begin
      dmain = (k % 3 == 0) ? 16'hFFFF : (k % 3 == 1) ? 16'h4000 : 16'h8000;
      dextra = k[0] ? 7'h7F : 7'h40;
      send_beat(REQ_ISSUE, 4'(k), k[1] ? 5'd31 : 5'd0, 5'(k), dmain, dextra,
                32'h0, 1'b0, 1'b1);
      if (k == 3) begin
        // A second issue while a load is outstanding is dropped; the first one stays.
        send_beat(REQ_ISSUE, K_LD16_W, 5'd31, 5'd7, 16'h1234, 7'h11, 32'h0, 1'b0, 1'b0);
      end
      if (k == 9) begin
        // Moving the PC under an outstanding load; the completion then wraps it.
        send_beat(REQ_SETPC, K_SLD_B, 5'd0, 5'd0, 16'h0, 7'h0, 32'hFFFF_FFFE, 1'b0, 1'b1);
      end
      if (k == 12) begin
        send_beat(REQ_WRITE, K_SLD_B, 5'd0, 5'd31, 16'h0, 7'h0, 32'h7FFF_FFFF, 1'b0, 1'b1);
      end
      // The response for kind 5 reports a bus error, so that load is aborted.
      send_beat(REQ_RESP, K_SLD_B, 5'd0, 5'd0, 16'h0, 7'h0,
                k[0] ? 32'hFFFF_FFFF : 32'h0000_8080, (k == 5), 1'b1);
    end

    // Random traffic in three idle mixes. The long output hold-off is requested at
    // the start of the last phase, where the sender never pauses.
    run_phase(18, 75, 400);
    run_phase(75, 18, 410);
    stall_request = 1'b1;
    run_phase(0, 0, 410);

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Summary: %0d input beats accepted (%0d loads, responses, writes and pc sets),",
             beats_sent, useful_beats);
    $display("  %0d results compared over three idle mixes and a %0d-cycle output stall.",
             results_checked, STALL_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
